/* rtl/core/mncm_pkg.sv */
// Shared types and constants of the masked neighbour count block.
// No dependencies; used by the top level and the axis span unit.
`default_nettype none

package mncm_pkg;

  // Field widths fixed by the interface
  localparam int unsigned IMG_SIZE_W = 13;
  localparam int unsigned MSK_SIZE_W = 5;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Request operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_HEIGHT  = 2'd3;

  // Range of mask indexes along one axis that land inside the image: [lo, hi)
  typedef struct packed {
    logic [MSK_SIZE_W-1:0] lo;
    logic [MSK_SIZE_W-1:0] hi;
  } span_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TPOS,
    ST_BOUNDS,
    ST_SCAN,
    ST_DRAIN
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/masked_neighbour_count_map.sv */
// Masked neighbour count: a mask write returns nothing.
// A valid query passes ST_TPOS, ST_BOUNDS, ST_SCAN and ST_DRAIN before its
// result, bound by the scan of one mask RAM entry per cycle; a rejected
// query answers from ST_TPOS. busy stays high until the result strobe, so
// the next request is taken at the earliest on the edge that takes the result.
// Reset sets all size registers to 1; the mask RAM holds garbage until written.
`default_nettype none

module masked_neighbour_count_map #(
  parameter int unsigned MASK_MAX_W = 16,
  parameter int unsigned MASK_MAX_H = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Request channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            op_i,
  input  wire logic [mncm_pkg::IDX_W-1:0]      mask_index_i,
  input  wire logic                            mask_bit_i,
  input  wire logic [mncm_pkg::POS_W-1:0]      pix_x_i,
  input  wire logic [mncm_pkg::POS_W-1:0]      pix_y_i,
  // Result channel
  output logic                                 result_valid_o,
  output logic [mncm_pkg::COUNT_W-1:0]         neighbour_count_o,
  output logic                                 out_of_range_o,
  // Configuration channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mncm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mncm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH = MASK_MAX_W * MASK_MAX_H;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LIM_W = 8;
  localparam logic [LIM_W-1:0] MaxW = LIM_W'(MASK_MAX_W);
  localparam logic [LIM_W-1:0] MaxH = LIM_W'(MASK_MAX_H);
  localparam logic [AW+mncm_pkg::IDX_W-1:0] DepthWide = (AW + mncm_pkg::IDX_W)'(DEPTH);

  mncm_pkg::state_e state_q, state_d;

  logic [mncm_pkg::IMG_SIZE_W-1:0] img_w_q, img_h_q;
  logic [mncm_pkg::MSK_SIZE_W-1:0] msk_w_q, msk_h_q;
  logic [mncm_pkg::POS_W-1:0]      pix_x_q, pix_y_q;

  logic [mncm_pkg::MSK_SIZE_W-1:0] i0_q, i0_d, i1_q, i1_d;
  logic [AW-1:0]                   addr_q, addr_d;
  logic                            rd_pend_q, rd_pend_d;
  logic                            hit_q, hit_d;
  logic [mncm_pkg::COUNT_W-1:0]    cnt_q, cnt_d;
  logic                            res_vld_d, res_oor_d;
  logic [mncm_pkg::COUNT_W-1:0]    res_cnt_d;

  logic                            accept;
  logic                            wr_en;
  logic [AW+mncm_pkg::IDX_W-1:0]   idx_wide;
  logic                            rd_en;
  logic                            rd_bit;
  logic                            reject;
  logic                            last;
  logic [mncm_pkg::COUNT_W-1:0]    cnt_inc;
  mncm_pkg::span_t                 span_x, span_y;

  assign busy        = (state_q != mncm_pkg::ST_IDLE);
  assign cfg_ready_o = !busy;
  assign accept      = start && !busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= mncm_pkg::IMG_SIZE_W'(1);
      img_h_q <= mncm_pkg::IMG_SIZE_W'(1);
      msk_w_q <= mncm_pkg::MSK_SIZE_W'(1);
      msk_h_q <= mncm_pkg::MSK_SIZE_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mncm_pkg::CFG_IMAGE_WIDTH:  img_w_q <= cfg_data_i;
        mncm_pkg::CFG_IMAGE_HEIGHT: img_h_q <= cfg_data_i;
        mncm_pkg::CFG_MASK_WIDTH:   msk_w_q <= cfg_data_i[mncm_pkg::MSK_SIZE_W-1:0];
        mncm_pkg::CFG_MASK_HEIGHT:  msk_h_q <= cfg_data_i[mncm_pkg::MSK_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the queried pixel
  always_ff @(posedge clk_i) begin
    if (accept && op_i == mncm_pkg::OP_QUERY) begin
      pix_x_q <= pix_x_i;
      pix_y_q <= pix_y_i;
    end
  end

  // Mask writes go straight to the RAM; busy keeps them clear of a scan
  assign idx_wide = (AW + mncm_pkg::IDX_W)'(mask_index_i);
  assign wr_en    = accept && (op_i == mncm_pkg::OP_WRITE) && (idx_wide < DepthWide);

  mncm_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mask_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(idx_wide[AW-1:0]),
    .wr_data_i(mask_bit_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(addr_q),
    .rd_data_o(rd_bit)
  );

  mncm_axis u_axis_x (
    .clk_i     (clk_i),
    .pos_i     (pix_x_q),
    .img_size_i(img_w_q),
    .msk_size_i(msk_w_q),
    .span_o    (span_x)
  );

  mncm_axis u_axis_y (
    .clk_i     (clk_i),
    .pos_i     (pix_y_q),
    .img_size_i(img_h_q),
    .msk_size_i(msk_h_q),
    .span_o    (span_y)
  );

  // Query cannot be answered
  assign reject = (msk_w_q == '0) || (msk_h_q == '0) ||
                  (LIM_W'(msk_w_q) > MaxW) || (LIM_W'(msk_h_q) > MaxH) ||
                  (img_w_q < mncm_pkg::IMG_SIZE_W'(msk_w_q)) ||
                  (img_h_q < mncm_pkg::IMG_SIZE_W'(msk_h_q)) ||
                  ({1'b0, pix_x_q} >= img_w_q) || ({1'b0, pix_y_q} >= img_h_q);

  assign last    = (i0_q == msk_w_q - mncm_pkg::MSK_SIZE_W'(1)) &&
                   (i1_q == msk_h_q - mncm_pkg::MSK_SIZE_W'(1));
  assign cnt_inc = cnt_q + mncm_pkg::COUNT_W'(rd_pend_q && hit_q && rd_bit);

  // Sequencer: next state, scan counters and result
  always_comb begin
    state_d   = state_q;
    i0_d      = i0_q;
    i1_d      = i1_q;
    addr_d    = addr_q;
    rd_en     = 1'b0;
    rd_pend_d = 1'b0;
    hit_d     = 1'b0;
    cnt_d     = cnt_inc;
    res_vld_d = 1'b0;
    res_oor_d = 1'b0;
    res_cnt_d = '0;
    unique case (state_q)
      mncm_pkg::ST_IDLE: begin
        if (accept && op_i == mncm_pkg::OP_QUERY) begin
          state_d = mncm_pkg::ST_TPOS;
        end
      end
      mncm_pkg::ST_TPOS: begin
        if (reject) begin
          res_vld_d = 1'b1;
          res_oor_d = 1'b1;
          state_d   = mncm_pkg::ST_IDLE;
        end else begin
          state_d = mncm_pkg::ST_BOUNDS;
        end
      end
      mncm_pkg::ST_BOUNDS: begin
        i0_d    = '0;
        i1_d    = '0;
        addr_d  = '0;
        cnt_d   = '0;
        state_d = mncm_pkg::ST_SCAN;
      end
      mncm_pkg::ST_SCAN: begin
        // Read one entry and tag whether it lands inside the image
        rd_en     = 1'b1;
        rd_pend_d = 1'b1;
        hit_d     = (i0_q >= span_x.lo) && (i0_q < span_x.hi) &&
                    (i1_q >= span_y.lo) && (i1_q < span_y.hi);
        addr_d    = addr_q + AW'(1);
        if (i0_q == msk_w_q - mncm_pkg::MSK_SIZE_W'(1)) begin
          i0_d = '0;
          i1_d = i1_q + mncm_pkg::MSK_SIZE_W'(1);
        end else begin
          i0_d = i0_q + mncm_pkg::MSK_SIZE_W'(1);
        end
        if (last) begin
          state_d = mncm_pkg::ST_DRAIN;
        end
      end
      mncm_pkg::ST_DRAIN: begin
        // Fold in the last read and present the result
        res_vld_d = 1'b1;
        res_cnt_d = cnt_inc;
        state_d   = mncm_pkg::ST_IDLE;
      end
      default: begin
        state_d = mncm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= mncm_pkg::ST_IDLE;
      rd_pend_q      <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      rd_pend_q      <= rd_pend_d;
      result_valid_o <= res_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    i0_q   <= i0_d;
    i1_q   <= i1_d;
    addr_q <= addr_d;
    hit_q  <= hit_d;
    cnt_q  <= cnt_d;
    if (res_vld_d) begin
      neighbour_count_o <= res_cnt_d;
      out_of_range_o    <= res_oor_d;
    end
  end

  // A result is only presented once the sequencer is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // A flagged result carries no count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && out_of_range_o) |-> (neighbour_count_o == '0))
    else $error("out-of-range result with nonzero count");

  // An accepted query occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == mncm_pkg::OP_QUERY) |=> busy)
    else $error("query accepted without going busy");

  // A mask write returns nothing and leaves the block free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == mncm_pkg::OP_WRITE) |=> (!busy && !result_valid_o))
    else $error("mask write caused activity");

  // Read data is only expected right after a scan cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(state_q == mncm_pkg::ST_SCAN))
    else $error("pending read without a scan");

endmodule

`default_nettype wire

/* rtl/core/mncm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mncm_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mncm_axis.sv */
// Per-axis template position and in-image index span, two register stages.
// Depends on mncm_pkg (span_t, field widths).
`default_nettype none

module mncm_axis (
  input  wire logic                            clk_i,
  input  wire logic [mncm_pkg::POS_W-1:0]      pos_i,
  input  wire logic [mncm_pkg::IMG_SIZE_W-1:0] img_size_i,
  input  wire logic [mncm_pkg::MSK_SIZE_W-1:0] msk_size_i,
  output mncm_pkg::span_t                      span_o
);

  logic [mncm_pkg::MSK_SIZE_W-1:0] marg;
  logic [mncm_pkg::IMG_SIZE_W-1:0] hi_edge;
  logic [mncm_pkg::IMG_SIZE_W-1:0] edge_gap;
  logic                            near_lo;
  logic                            near_hi;
  logic [mncm_pkg::MSK_SIZE_W-1:0] tpos_d;
  logic [mncm_pkg::MSK_SIZE_W-1:0] tpos_q;
  logic [mncm_pkg::MSK_SIZE_W-1:0] marg_q;
  mncm_pkg::span_t                 span_d;

  // Margin is (size-1)/2
  assign marg     = (msk_size_i - mncm_pkg::MSK_SIZE_W'(1)) >> 1;
  assign near_lo  = pos_i < mncm_pkg::POS_W'(marg);
  assign hi_edge  = img_size_i - mncm_pkg::IMG_SIZE_W'(marg);
  assign near_hi  = {1'b0, pos_i} >= hi_edge;
  assign edge_gap = img_size_i - {1'b0, pos_i};

  // Map the pixel onto the template, clamping at the borders
  always_comb begin
    priority if (near_lo) begin
      tpos_d = pos_i[mncm_pkg::MSK_SIZE_W-1:0];
    end else if (near_hi) begin
      tpos_d = msk_size_i - edge_gap[mncm_pkg::MSK_SIZE_W-1:0];
    end else begin
      tpos_d = marg;
    end
  end

  // Index i lands inside when marg <= t + i < marg + size
  always_comb begin
    span_d.lo = (marg_q > tpos_q) ? (marg_q - tpos_q) : '0;
    span_d.hi = (tpos_q > marg_q) ? (msk_size_i - (tpos_q - marg_q)) : msk_size_i;
  end

  // Inputs hold steady for a whole query, so the stages run freely
  always_ff @(posedge clk_i) begin
    tpos_q <= tpos_d;
    marg_q <= marg;
    span_o <= span_d;
  end

endmodule

`default_nettype wire
